### src/hct_pkg.sv
// hct_pkg: shared types, codes and constants of the heating cycle timer
// used by hct_cfg, hct_core and heating_cycle_timer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hct_pkg;

  // opcodes of an input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_PAUSE = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  // run modes
  localparam logic [1:0] MODE_STOPPED = 2'd0;
  localparam logic [1:0] MODE_HEATING = 2'd1;
  localparam logic [1:0] MODE_PAUSED  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_TEMP = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CYCLE_TIME  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VALID   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VALID   = 4'd3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [11:0] MAX_VALID_RESET = 12'd4095;
  localparam logic [6:0]  BAD_READ_LIMIT  = 7'd100;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [11:0] sample_temp;
  } item_t;

  typedef struct packed {
    logic [1:0]  run_state;
    logic        heater_enable;
    logic        cycle_done;
    logic        regulate_now;
    logic [11:0] temperature;
    logic [11:0] setpoint;
    logic        sensor_alarm;
    logic [30:0] remaining_ms;
  } result_t;

  typedef struct packed {
    logic [9:0]  target_temp_deg;
    logic [31:0] cycle_time_ms;
    logic [11:0] min_valid_temp;
    logic [11:0] max_valid_temp;
  } cfg_t;

endpackage

`default_nettype wire

### src/heating_cycle_timer.sv
// heating_cycle_timer: top level with input register and result register
// depends on hct_pkg, hct_cfg, hct_core
`timescale 1ns / 1ps
`default_nettype none

// Heating cycle timer. Each input transaction (sample tick, start, pause or
// resume, stop) yields exactly one result transaction. A transaction is
// held in an input register, updated against the cycle state by the core
// logic, and lands in a result register; the block takes one transaction
// every cycle when the result side does not stall. The single update step
// of the mode, timing and sensor-check registers sets that rate. Configuration
// writes are taken at any time (cfg_ready is always high) but must be made
// while no transaction is in flight. Reset is synchronous; no clearing pass
// follows.

module heating_cycle_timer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire hct_pkg::item_t                  item,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output hct_pkg::result_t                     result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hct_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [hct_pkg::CFG_DATA_W-1:0]  cfg_data
);

  hct_pkg::cfg_t    cfg;
  hct_pkg::item_t   item_q;
  hct_pkg::result_t core_result;
  logic             item_full;
  logic             advance;
  logic             fire;

  hct_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // result register can take a new transaction
  assign advance    = !result_valid || !result_stall;
  assign fire       = item_full && advance;
  assign item_stall = item_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (!item_stall) begin
      item_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      item_q <= item;
    end
  end

  hct_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item_q),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= item_full;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= core_result;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.heater_enable == (result.run_state == hct_pkg::MODE_HEATING)))
    else $error("heater enable disagrees with run state");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.cycle_done) |->
      (result.run_state == hct_pkg::MODE_STOPPED) && !result.regulate_now)
    else $error("cycle done with heater still running");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.run_state == hct_pkg::MODE_STOPPED)) |->
      (result.remaining_ms == 31'd0))
    else $error("time left while stopped");

endmodule

`default_nettype wire

### src/hct_cfg.sv
// hct_cfg: configuration register file of the heating cycle timer
// depends on hct_pkg
`timescale 1ns / 1ps
`default_nettype none

module hct_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hct_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [hct_pkg::CFG_DATA_W-1:0]  cfg_data,
  output hct_pkg::cfg_t                        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_temp_deg <= '0;
      cfg.cycle_time_ms   <= '0;
      cfg.min_valid_temp  <= '0;
      cfg.max_valid_temp  <= hct_pkg::MAX_VALID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hct_pkg::CFG_TARGET_TEMP: cfg.target_temp_deg <= cfg_data[9:0];
        hct_pkg::CFG_CYCLE_TIME:  cfg.cycle_time_ms   <= cfg_data[31:0];
        hct_pkg::CFG_MIN_VALID:   cfg.min_valid_temp  <= cfg_data[11:0];
        hct_pkg::CFG_MAX_VALID:   cfg.max_valid_temp  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/hct_core.sv
// hct_core: cycle state registers and the per-transaction update logic
// depends on hct_pkg
`timescale 1ns / 1ps
`default_nettype none

module hct_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire hct_pkg::item_t item,
  input  wire hct_pkg::cfg_t  cfg,
  output hct_pkg::result_t    result
);

  logic [1:0]  mode, mode_next;
  // start time plus accumulated pause time
  logic [31:0] base_time, base_time_next;
  logic [31:0] pause_start, pause_start_next;
  logic [6:0]  bad_count, bad_count_next;
  logic [11:0] held_temp, held_temp_next;
  logic [11:0] held_sp, held_sp_next;
  logic        alarm, alarm_next;

  logic        good_read;
  logic [31:0] deadline;
  logic        time_up;
  logic [11:0] sp_request;
  logic [6:0]  bad_inc;
  logic        start_taken;
  logic [31:0] rem_ref;
  logic [31:0] rem_full;
  logic        done;
  logic        regulate;

  always_comb begin
    mode_next        = mode;
    base_time_next   = base_time;
    pause_start_next = pause_start;
    bad_count_next   = bad_count;
    held_temp_next   = held_temp;
    held_sp_next     = held_sp;
    alarm_next       = alarm;
    done             = 1'b0;
    regulate         = 1'b0;

    good_read   = (item.sample_temp >= cfg.min_valid_temp) &&
                  (item.sample_temp <= cfg.max_valid_temp);
    deadline    = base_time + cfg.cycle_time_ms;
    time_up     = item.now_ms >= deadline;
    sp_request  = {cfg.target_temp_deg, 2'b00};
    bad_inc     = bad_count + 7'd1;
    start_taken = (item.opcode == hct_pkg::OP_START) && (mode == hct_pkg::MODE_STOPPED);

    unique case (item.opcode)
      hct_pkg::OP_TICK: begin
        if (good_read) begin
          held_temp_next = item.sample_temp;
          alarm_next     = 1'b0;
        end else if (bad_inc > hct_pkg::BAD_READ_LIMIT) begin
          held_temp_next = cfg.max_valid_temp;
          alarm_next     = 1'b1;
          bad_count_next = '0;
        end else begin
          bad_count_next = bad_inc;
        end
        if (mode == hct_pkg::MODE_HEATING) begin
          if (time_up) begin
            mode_next = hct_pkg::MODE_STOPPED;
            done      = 1'b1;
          end else begin
            regulate = 1'b1;
          end
        end
      end
      hct_pkg::OP_START: begin
        if (start_taken) begin
          held_sp_next   = (sp_request > cfg.max_valid_temp) ? cfg.max_valid_temp
                                                             : sp_request;
          base_time_next = item.now_ms;
          mode_next      = hct_pkg::MODE_HEATING;
        end
      end
      hct_pkg::OP_PAUSE: begin
        if (mode == hct_pkg::MODE_HEATING) begin
          pause_start_next = item.now_ms;
          mode_next        = hct_pkg::MODE_PAUSED;
        end else if (mode == hct_pkg::MODE_PAUSED) begin
          base_time_next = base_time + (item.now_ms - pause_start);
          mode_next      = hct_pkg::MODE_HEATING;
        end
      end
      hct_pkg::OP_STOP: begin
        mode_next = hct_pkg::MODE_STOPPED;
      end
      default: ;
    endcase

    // time left after the update: the pause and resume shifts cancel out, so
    // only the old mode picks the reference time
    rem_ref  = (mode == hct_pkg::MODE_PAUSED) ? pause_start : item.now_ms;
    rem_full = start_taken ? cfg.cycle_time_ms : (deadline - rem_ref);

    result.run_state     = mode_next;
    result.heater_enable = (mode_next == hct_pkg::MODE_HEATING);
    result.cycle_done    = done;
    result.regulate_now  = regulate;
    result.temperature   = held_temp_next;
    result.setpoint      = held_sp_next;
    result.sensor_alarm  = alarm_next;
    result.remaining_ms  = ((mode_next == hct_pkg::MODE_STOPPED) || rem_full[31])
                           ? 31'd0 : rem_full[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= hct_pkg::MODE_STOPPED;
      base_time   <= '0;
      pause_start <= '0;
      bad_count   <= '0;
      held_temp   <= '0;
      held_sp     <= '0;
      alarm       <= 1'b0;
    end else if (fire) begin
      mode        <= mode_next;
      base_time   <= base_time_next;
      pause_start <= pause_start_next;
      bad_count   <= bad_count_next;
      held_temp   <= held_temp_next;
      held_sp     <= held_sp_next;
      alarm       <= alarm_next;
    end
  end

  // the counter wraps to zero once it passes the limit
  assert property (@(posedge clk) disable iff (rst)
    bad_count <= hct_pkg::BAD_READ_LIMIT)
    else $error("bad read count above limit");

  // the alarm is raised only by a bad reading on a tick
  assert property (@(posedge clk) disable iff (rst)
    (fire && !alarm && alarm_next) |->
      (item.opcode == hct_pkg::OP_TICK) && !good_read)
    else $error("alarm raised without bad reading");

  // state holds between transactions
  assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(mode) && $stable(base_time) && $stable(bad_count))
    else $error("state changed without a transaction");

endmodule

`default_nettype wire

### tb/sv/tb_heating_cycle_timer.sv
// tb_heating_cycle_timer: self-checking testbench for the heating cycle timer
// scoreboard class tracks mode, timing and sensor state and predicts each status
// depends on hct_pkg and heating_cycle_timer
`timescale 1ns / 1ps

module tb_heating_cycle_timer;
  import hct_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_TOP_INDEX = '1;

  class cycle_scoreboard;
    logic [9:0]  target_deg;
    logic [31:0] cycle_ms;
    logic [11:0] min_temp;
    logic [11:0] max_temp;

    logic [1:0]  mode;
    logic [31:0] start_ms;
    logic [31:0] pause_ms;
    logic [31:0] paused_total;
    logic [6:0]  bad_reads;
    logic [11:0] temp_q;
    logic [11:0] setpoint_q;
    logic        alarm;

    result_t     status_due[$];
    int unsigned errors;
    int unsigned commands;
    int unsigned finished_cycles;
    int unsigned alarms_raised;

    function new();
      target_deg      = '0;
      cycle_ms        = '0;
      min_temp        = '0;
      max_temp        = MAX_VALID_RESET;
      mode            = MODE_STOPPED;
      start_ms        = '0;
      pause_ms        = '0;
      paused_total    = '0;
      bad_reads       = '0;
      temp_q          = '0;
      setpoint_q      = '0;
      alarm           = 1'b0;
      errors          = 0;
      commands        = 0;
      finished_cycles = 0;
      alarms_raised   = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_TARGET_TEMP: target_deg = data[9:0];
        CFG_CYCLE_TIME:  cycle_ms   = data;
        CFG_MIN_VALID:   min_temp   = data[11:0];
        CFG_MAX_VALID:   max_temp   = data[11:0];
        default: ;
      endcase
    endfunction

    // advance the cycle state by one command and queue the status it yields
    function void note_command(item_t cmd);
      result_t     st;
      logic [31:0] deadline;
      logic [31:0] base;
      logic [31:0] elapsed;
      logic [31:0] left;
      logic [11:0] sp;
      logic        done;
      logic        regulate;
      done     = 1'b0;
      regulate = 1'b0;
      commands++;
      case (cmd.opcode)
        OP_TICK: begin
          if (cmd.sample_temp >= min_temp && cmd.sample_temp <= max_temp) begin
            temp_q = cmd.sample_temp;
            alarm  = 1'b0;
          end else begin
            bad_reads = bad_reads + 7'd1;
            if (bad_reads > BAD_READ_LIMIT) begin
              temp_q    = max_temp;
              alarm     = 1'b1;
              bad_reads = '0;
              alarms_raised++;
            end
          end
          if (mode == MODE_HEATING) begin
            deadline = start_ms + cycle_ms + paused_total;
            if (cmd.now_ms >= deadline) begin
              mode = MODE_STOPPED;
              done = 1'b1;
              finished_cycles++;
            end else begin
              regulate = 1'b1;
            end
          end
        end
        OP_START: begin
          if (mode == MODE_STOPPED) begin
            sp           = {target_deg, 2'b00};
            setpoint_q   = (sp > max_temp) ? max_temp : sp;
            start_ms     = cmd.now_ms;
            paused_total = '0;
            mode         = MODE_HEATING;
          end
        end
        OP_PAUSE: begin
          if (mode == MODE_HEATING) begin
            pause_ms = cmd.now_ms;
            mode     = MODE_PAUSED;
          end else if (mode == MODE_PAUSED) begin
            paused_total = paused_total + (cmd.now_ms - pause_ms);
            mode         = MODE_HEATING;
          end
        end
        default: mode = MODE_STOPPED;
      endcase

      // time left: paused cycles freeze the elapsed time at the pause point
      base    = start_ms + paused_total;
      elapsed = (mode == MODE_HEATING) ? cmd.now_ms - base : pause_ms - base;
      left    = cycle_ms - elapsed;

      st.run_state     = mode;
      st.heater_enable = (mode == MODE_HEATING);
      st.cycle_done    = done;
      st.regulate_now  = regulate;
      st.temperature   = temp_q;
      st.setpoint      = setpoint_q;
      st.sensor_alarm  = alarm;
      st.remaining_ms  = (mode == MODE_STOPPED || left[31]) ? '0 : left[30:0];
      status_due.push_back(st);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_status(result_t got);
      result_t want;
      if (status_due.size() == 0) begin
        $display("%0t: status with no command outstanding, actual 0x%0h", $time, got);
        errors++;
        return;
      end
      want = status_due.pop_front();
      check_field("run_state",     32'(want.run_state),     32'(got.run_state));
      check_field("heater_enable", 32'(want.heater_enable), 32'(got.heater_enable));
      check_field("cycle_done",    32'(want.cycle_done),    32'(got.cycle_done));
      check_field("regulate_now",  32'(want.regulate_now),  32'(got.regulate_now));
      check_field("temperature",   32'(want.temperature),   32'(got.temperature));
      check_field("setpoint",      32'(want.setpoint),      32'(got.setpoint));
      check_field("sensor_alarm",  32'(want.sensor_alarm),  32'(got.sensor_alarm));
      check_field("remaining_ms",  32'(want.remaining_ms),  32'(got.remaining_ms));
    endfunction

    function int unsigned pending();
      return status_due.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_stall;
  item_t                  item;
  logic                   result_valid;
  logic                   result_stall;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cycle_scoreboard sb;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_left;
  int unsigned sent;
  logic [31:0] clock_ms;
  logic [31:0] step_max;

  heating_cycle_timer u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result side: long hold-off when requested, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_status(result);
  end

  // valid stays high between back-to-back transactions; only source idling and wait_idle lower it
  task automatic send_item(input item_t cmd);
    while ($urandom_range(99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= cmd;
    do @(posedge clk); while (item_stall);
    sb.note_command(cmd);
    sent++;
  endtask

  task automatic send_at(input logic [1:0] op, input logic [31:0] now,
                         input logic [11:0] sample);
    item_t cmd;
    cmd.opcode      = op;
    cmd.now_ms      = now;
    cmd.sample_temp = sample;
    send_item(cmd);
  endtask

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: return 12'($urandom_range(4095));
      default: begin
        if (sb.min_temp <= sb.max_temp)
          return 12'($urandom_range(sb.max_temp, sb.min_temp));
        return 12'($urandom_range(4095));
      end
    endcase
  endfunction

  task automatic send_cmd(input logic [1:0] op);
    clock_ms = clock_ms + $urandom_range(step_max);
    send_at(op, clock_ms, pick_sample());
  endtask

  // mostly well-formed heating cycles, with some fully random transactions
  task automatic run_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned len;
    int unsigned roll;
    stop_at = sent + count;
    while (sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        send_cmd(OP_START);
        len = $urandom_range(12, 2);
        repeat (len) begin
          roll = $urandom_range(99);
          if (roll < 70)
            send_cmd(OP_TICK);
          else if (roll < 85)
            send_cmd(OP_PAUSE);
          else if (roll < 92)
            send_cmd(OP_START);
          else
            send_cmd(OP_STOP);
        end
      end else begin
        send_at(2'($urandom_range(3)), $urandom, 12'($urandom_range(4095)));
      end
    end
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // cfg_valid stays high across the back-to-back writes of one update
  task automatic put_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
  endtask

  task automatic write_config(input logic [31:0] target, input logic [31:0] cycle,
                              input logic [31:0] lo, input logic [31:0] hi);
    logic [CFG_INDEX_W-1:0] spare_idx;
    spare_idx = CFG_INDEX_W'($urandom_range(CFG_TOP_INDEX, CFG_MAX_VALID + 1));
    put_register(CFG_TARGET_TEMP, target);
    put_register(CFG_CYCLE_TIME, cycle);
    put_register(CFG_MIN_VALID, lo);
    put_register(CFG_MAX_VALID, hi);
    // unused indexes must leave every register alone
    put_register(CFG_TOP_INDEX, $urandom);
    put_register(spare_idx, $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb             = new();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 0;
    sent           = 0;
    clock_ms       = '0;
    step_max       = 32'd10;
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    item         <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset limits accept any reading
    send_at(OP_TICK, 32'd0, 12'hFFF);
    wait_idle();

    write_config(32'd1023, 32'd100, 32'd400, 32'd3000);
    send_at(OP_TICK, 32'd0, 12'd0);
    send_at(OP_TICK, 32'd10, 12'hFFF);
    send_at(OP_TICK, 32'd20, 12'd400);
    send_at(OP_TICK, 32'd30, 12'd3000);
    send_at(OP_TICK, 32'd40, 12'd399);
    send_at(OP_TICK, 32'd50, 12'd3001);
    send_at(OP_PAUSE, 32'd60, 12'd0);
    send_at(OP_STOP, 32'd70, 12'd0);
    // setpoint 4092 clamps to the upper limit
    send_at(OP_START, 32'd1000, 12'hFFF);
    send_at(OP_START, 32'd1010, 12'd0);
    send_at(OP_TICK, 32'd1050, 12'd1000);
    send_at(OP_PAUSE, 32'd1060, 12'd0);
    send_at(OP_TICK, 32'd1500, 12'd1200);
    send_at(OP_PAUSE, 32'd1560, 12'd0);
    send_at(OP_TICK, 32'd1599, 12'd1300);
    send_at(OP_TICK, 32'd1600, 12'd1400);
    // deadline wraps past zero
    send_at(OP_START, 32'hFFFF_FFC0, 12'd0);
    send_at(OP_TICK, 32'hFFFF_FFF0, 12'd2000);
    send_at(OP_START, 32'd2000, 12'd0);
    send_at(OP_STOP, 32'd2050, 12'd0);
    send_at(OP_START, 32'd3000, 12'd0);
    send_at(OP_PAUSE, 32'd3010, 12'd0);
    send_at(OP_STOP, 32'd3020, 12'd0);
    send_at(OP_TICK, 32'hFFFF_FFFF, 12'hFFF);
    wait_idle();

    // back to back, time running across the 32-bit wrap
    write_config($urandom_range(1023), $urandom_range(3000, 50), $urandom_range(600),
                 $urandom_range(4095, 3000));
    step_max = sb.cycle_ms / 4 + 1;
    clock_ms = 32'hFFFF_F000;
    run_traffic(50);
    wait_idle();
    run_traffic(50);
    wait_idle();

    // zero cycle time, all readings plausible, sender mostly idle
    write_config(32'd1023, 32'd0, 32'd0, 32'd4095);
    step_max     = 32'd50;
    src_idle_pct = 76;
    run_traffic(100);
    wait_idle();

    // longest cycle time, inverted limits, receiver mostly stalled
    write_config(32'd0, 32'hFFFF_FFFF, 32'd4095, 32'd0);
    step_max       = 32'h4000_0000;
    src_idle_pct   = 0;
    sink_stall_pct = 76;
    run_traffic(100);
    wait_idle();

    // random settings, light idling on both sides
    write_config($urandom, $urandom_range(5000), $urandom_range(4095), $urandom_range(4095));
    step_max       = sb.cycle_ms / 3 + 1;
    src_idle_pct   = 8;
    sink_stall_pct = 8;
    run_traffic(100);
    wait_idle();

    // long hold-off on the result side while commands keep coming
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 80;
    run_traffic(30);
    wait_idle();

    repeat (10) @(posedge clk);
    $display("run covered %0d commands: directed limits, wrap-around, pauses, stops",
             sb.commands);
    $display("idle/stall/hold-off phases saw %0d finished cycles and %0d sensor alarms",
             sb.finished_cycles, sb.alarms_raised);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d statuses outstanding", sb.errors, sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d statuses outstanding", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
